// ----- rtl/btit_pkg.sv -----
// Shared types, codes and constants of the bitmap tag index table.
package btit_pkg;

	localparam int DEF_TABLE_DEPTH = 64;
	localparam int DEF_BITMAP_BITS = 128;
	localparam int WORD_BITS = 64;
	localparam int KEY_W = 32;
	localparam int KIND_W = 3;
	localparam int STATUS_W = 2;
	localparam int COUNT_W = 7;

	localparam logic [KIND_W-1:0] KIND_INSERT = 3'd0;
	localparam logic [KIND_W-1:0] KIND_REMOVE = 3'd1;
	localparam logic [KIND_W-1:0] KIND_MATCH_ANY = 3'd2;
	localparam logic [KIND_W-1:0] KIND_MATCH_ALL = 3'd3;
	localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd4;

	localparam logic [STATUS_W-1:0] STATUS_OK = 2'd0;
	localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd1;
	localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;

	typedef struct packed {
		logic is_query;
		logic match_all;
		logic nonempty;
		logic entry_valid;
	} cmp_ctrl_t;

endpackage

// ----- rtl/btit_cmp.sv -----
// Shared compare unit: key equality and bitmap any/all test for one table entry.
module btit_cmp import btit_pkg::*; #(
	parameter int BITMAP_BITS = DEF_BITMAP_BITS
) (
	input  cmp_ctrl_t              ctrl,
	input  logic [KEY_W-1:0]       req_key,
	input  logic [KEY_W-1:0]       entry_key,
	input  logic [BITMAP_BITS-1:0] query,
	input  logic [BITMAP_BITS-1:0] entry_bits,
	output logic                   key_hit,
	output logic                   bits_hit
);

	logic [BITMAP_BITS-1:0] common_c;
	logic                   any_c;
	logic                   all_c;

	assign common_c = entry_bits & query;
	assign any_c = |common_c;
	assign all_c = (common_c == query);

	assign key_hit = ctrl.entry_valid && !ctrl.is_query && (entry_key == req_key);
	assign bits_hit = ctrl.entry_valid && ctrl.is_query && ctrl.nonempty &&
		(ctrl.match_all ? all_c : any_c);

endmodule

// ----- rtl/bitmap_tag_index_table_unit.sv -----
// Top level of the bitmap tag index table: sequencer, entry memories and output register.
// Insert, remove and queries scan one entry per cycle, held while a waiting result is stalled;
// clear and unknown kinds skip the scan and go straight to the finish state.
// The last result is registered as the item leaves the finish state.
// Query hits stream out in slot order while the scan runs; one item is handled at a time.
// Reset clears valid bits, key count and control state; key and bitmap memories are not.
module bitmap_tag_index_table_unit import btit_pkg::*; #(
	parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
	parameter int BITMAP_BITS = DEF_BITMAP_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  logic [KIND_W-1:0]     kind,
	input  logic [KEY_W-1:0]      key,
	input  logic [WORD_BITS-1:0]  bits_low,
	input  logic [WORD_BITS-1:0]  bits_high,
	output logic                  out_valid,
	input  logic                  out_stall,
	output logic [KEY_W-1:0]      match_key,
	output logic                  matched,
	output logic [STATUS_W-1:0]   status,
	output logic [COUNT_W-1:0]    stored_count,
	output logic                  last
);

	localparam int IW = $clog2(TABLE_DEPTH);
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_DEPTH - 1);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_FIN = 2'd2;

	logic [1:0]             state_q;
	logic [KIND_W-1:0]      kind_q;
	logic [KEY_W-1:0]       key_q;
	logic [BITMAP_BITS-1:0] query_q;
	logic                   qnz_q;
	logic [IW-1:0]          ptr_q;
	logic [TABLE_DEPTH-1:0] valid_q;
	logic [COUNT_W-1:0]     count_q;
	logic                   found_q;
	logic [IW-1:0]          found_idx_q;
	logic                   free_found_q;
	logic [IW-1:0]          free_idx_q;
	logic                   pend_vld_q;
	logic [KEY_W-1:0]       pend_key_q;

	logic [KEY_W-1:0]       key_mem [TABLE_DEPTH];
	logic [BITMAP_BITS-1:0] bits_mem [TABLE_DEPTH];
	logic [KEY_W-1:0]       key_rd_q;
	logic [BITMAP_BITS-1:0] bits_rd_q;

	logic                   out_valid_q;
	logic [KEY_W-1:0]       match_key_q;
	logic                   matched_q;
	logic [STATUS_W-1:0]    status_q;
	logic [COUNT_W-1:0]     stored_count_q;
	logic                   last_q;

	logic [2*WORD_BITS-1:0] full_bits_c;
	logic [BITMAP_BITS-1:0] query_c;
	logic                   accept_c;
	logic                   scan_kind_c;
	logic                   out_free_c;
	cmp_ctrl_t              cmp_ctrl_c;
	logic                   key_hit_c;
	logic                   bits_hit_c;
	logic                   in_scan_c;
	logic                   advance_c;
	logic                   push_pend_c;
	logic                   fin_go_c;
	logic [IW-1:0]          next_ptr_c;
	logic [IW-1:0]          rd_addr_c;
	logic                   wr_en_c;
	logic [IW-1:0]          wr_idx_c;
	logic [COUNT_W-1:0]     count_nxt_c;
	logic [STATUS_W-1:0]    fin_status_c;

	assign full_bits_c = {bits_high, bits_low};
	assign query_c = full_bits_c[BITMAP_BITS-1:0];
	assign in_stall = (state_q != ST_IDLE);
	assign accept_c = in_valid && !in_stall;
	assign scan_kind_c = (kind == KIND_INSERT) || (kind == KIND_REMOVE) ||
		(kind == KIND_MATCH_ANY) || (kind == KIND_MATCH_ALL);
	assign out_free_c = !out_valid_q || !out_stall;

	assign cmp_ctrl_c.is_query = (kind_q == KIND_MATCH_ANY) || (kind_q == KIND_MATCH_ALL);
	assign cmp_ctrl_c.match_all = (kind_q == KIND_MATCH_ALL);
	assign cmp_ctrl_c.nonempty = qnz_q;
	assign cmp_ctrl_c.entry_valid = valid_q[ptr_q];

	btit_cmp #(
		.BITMAP_BITS(BITMAP_BITS)
	) u_cmp (
		.ctrl       (cmp_ctrl_c),
		.req_key    (key_q),
		.entry_key  (key_rd_q),
		.query      (query_q),
		.entry_bits (bits_rd_q),
		.key_hit    (key_hit_c),
		.bits_hit   (bits_hit_c)
	);

	assign in_scan_c = (state_q == ST_SCAN);
	assign push_pend_c = in_scan_c && bits_hit_c && pend_vld_q;
	assign advance_c = in_scan_c && !(push_pend_c && !out_free_c);
	assign fin_go_c = (state_q == ST_FIN) && out_free_c;
	assign next_ptr_c = (ptr_q == LAST_IDX) ? '0 : ptr_q + IW'(1);

	always_comb begin
		rd_addr_c = '0;
		if (in_scan_c) begin
			rd_addr_c = advance_c ? next_ptr_c : ptr_q;
		end
	end

	always_comb begin
		count_nxt_c = count_q;
		fin_status_c = STATUS_OK;
		case (kind_q)
			KIND_INSERT: begin
				if (!found_q && free_found_q) begin
					count_nxt_c = count_q + COUNT_W'(1);
				end
				if (!found_q && !free_found_q) begin
					fin_status_c = STATUS_FULL;
				end
			end
			KIND_REMOVE: begin
				if (found_q && count_q != '0) begin
					count_nxt_c = count_q - COUNT_W'(1);
				end
				if (!found_q) begin
					fin_status_c = STATUS_NOT_FOUND;
				end
			end
			KIND_CLEAR: begin
				count_nxt_c = '0;
			end
			default: begin
				count_nxt_c = count_q;
			end
		endcase
	end

	assign wr_en_c = fin_go_c && (kind_q == KIND_INSERT) && (found_q || free_found_q);
	assign wr_idx_c = found_q ? found_idx_q : free_idx_q;

	always_ff @(posedge clk) begin
		key_rd_q <= key_mem[rd_addr_c];
		bits_rd_q <= bits_mem[rd_addr_c];
		if (wr_en_c) begin
			key_mem[wr_idx_c] <= key_q;
			bits_mem[wr_idx_c] <= query_q;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_c) begin
			key_q <= key;
			query_q <= query_c;
		end
		if (advance_c && key_hit_c && !found_q) begin
			found_idx_q <= ptr_q;
		end
		if (advance_c && (kind_q == KIND_INSERT) && !valid_q[ptr_q] && !free_found_q) begin
			free_idx_q <= ptr_q;
		end
		if (advance_c && bits_hit_c) begin
			pend_key_q <= key_rd_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			kind_q <= KIND_INSERT;
			qnz_q <= 1'b0;
			ptr_q <= '0;
			valid_q <= '0;
			count_q <= '0;
			found_q <= 1'b0;
			free_found_q <= 1'b0;
			pend_vld_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept_c) begin
						kind_q <= kind;
						qnz_q <= |query_c;
						ptr_q <= '0;
						found_q <= 1'b0;
						free_found_q <= 1'b0;
						pend_vld_q <= 1'b0;
						state_q <= scan_kind_c ? ST_SCAN : ST_FIN;
					end
				end
				ST_SCAN: begin
					if (advance_c) begin
						if (key_hit_c) begin
							found_q <= 1'b1;
						end
						if ((kind_q == KIND_INSERT) && !valid_q[ptr_q]) begin
							free_found_q <= 1'b1;
						end
						if (bits_hit_c) begin
							pend_vld_q <= 1'b1;
						end
						ptr_q <= next_ptr_c;
						if (ptr_q == LAST_IDX) begin
							state_q <= ST_FIN;
						end
					end
				end
				ST_FIN: begin
					if (fin_go_c) begin
						count_q <= count_nxt_c;
						if (kind_q == KIND_INSERT && !found_q && free_found_q) begin
							valid_q[free_idx_q] <= 1'b1;
						end
						if (kind_q == KIND_REMOVE && found_q) begin
							valid_q[found_idx_q] <= 1'b0;
						end
						if (kind_q == KIND_CLEAR) begin
							valid_q <= '0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (fin_go_c || (advance_c && push_pend_c)) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance_c && push_pend_c) begin
			match_key_q <= pend_key_q;
			matched_q <= 1'b1;
			status_q <= STATUS_OK;
			stored_count_q <= count_q;
			last_q <= 1'b0;
		end else if (fin_go_c) begin
			match_key_q <= pend_vld_q ? pend_key_q : '0;
			matched_q <= pend_vld_q;
			status_q <= fin_status_c;
			stored_count_q <= count_nxt_c;
			last_q <= 1'b1;
		end
	end

	assign out_valid = out_valid_q;
	assign match_key = match_key_q;
	assign matched = matched_q;
	assign status = status_q;
	assign stored_count = stored_count_q;
	assign last = last_q;

	a_count_tracks_valid: assert property (@(posedge clk) disable iff (!arst_n)
		COUNT_W'($countones(valid_q)) == count_q)
		else $error("key count differs from the number of valid entries");

	a_count_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= COUNT_W'(TABLE_DEPTH))
		else $error("key count exceeds the table depth");

	a_fin_emits_last: assert property (@(posedge clk) disable iff (!arst_n)
		fin_go_c |=> out_valid && last && state_q == ST_IDLE)
		else $error("finished item did not present its last result");

	a_inner_result_matched: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !last |-> matched && status == STATUS_OK)
		else $error("result before the last one is not a match");

endmodule

// ----- verif/tb.sv -----
// Self-checking testbench for the bitmap tag index table with a scoreboard-based table predictor.
module tb import btit_pkg::*; ();

	localparam int SLOTS = DEF_TABLE_DEPTH;
	localparam int POOL = 72;
	localparam logic [KIND_W-1:0] KIND_SPARE_FIRST = 3'd5;

	typedef struct packed {
		logic [KEY_W-1:0]    mkey;
		logic                hit;
		logic [STATUS_W-1:0] st;
		logic [COUNT_W-1:0]  cnt;
		logic                lst;
	} table_reply_t;

	typedef struct packed {
		logic [KIND_W-1:0]    kind;
		logic [KEY_W-1:0]     id;
		logic [WORD_BITS-1:0] lo;
		logic [WORD_BITS-1:0] hi;
		logic                 typed;
		logic [STATUS_W-1:0]  st;
		logic [COUNT_W-1:0]   cnt;
	} request_row_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [KIND_W-1:0]    kind = KIND_INSERT;
	logic [KEY_W-1:0]     key = '0;
	logic [WORD_BITS-1:0] bits_low = '0;
	logic [WORD_BITS-1:0] bits_high = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [KEY_W-1:0]     match_key;
	logic                 matched;
	logic [STATUS_W-1:0]  status;
	logic [COUNT_W-1:0]   stored_count;
	logic                 last;

	logic                 slot_used [SLOTS];
	logic [KEY_W-1:0]     slot_key [SLOTS];
	logic [WORD_BITS-1:0] slot_lo [SLOTS];
	logic [WORD_BITS-1:0] slot_hi [SLOTS];
	int unsigned          stored_keys = 0;

	table_reply_t reply_queue [$];
	table_reply_t scan_hits [$];
	request_row_t directed_rows [$];
	logic [KEY_W-1:0] key_pool [POOL];

	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	logic hold_req = 1'b0;
	logic hold_done = 1'b0;
	int hold_left = 0;
	int err_count = 0;

	bitmap_tag_index_table_unit u_top (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.kind(kind),
		.key(key),
		.bits_low(bits_low),
		.bits_high(bits_high),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.match_key(match_key),
		.matched(matched),
		.status(status),
		.stored_count(stored_count),
		.last(last)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic void apply_request(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] id,
			input logic [WORD_BITS-1:0] lo, input logic [WORD_BITS-1:0] hi);
		int slot;
		logic hit;
		table_reply_t r;
		scan_hits.delete();
		r = '0;
		r.st = STATUS_OK;
		r.lst = 1'b1;
		slot = -1;
		case (k)
			KIND_INSERT: begin
				for (int i = 0; i < SLOTS; i++)
					if (slot < 0 && slot_used[i] && slot_key[i] == id)
						slot = i;
				if (slot < 0)
					for (int i = 0; i < SLOTS; i++)
						if (slot < 0 && !slot_used[i])
							slot = i;
				if (slot < 0) begin
					r.st = STATUS_FULL;
				end else begin
					if (!slot_used[slot]) begin
						slot_used[slot] = 1'b1;
						slot_key[slot] = id;
						stored_keys++;
					end
					slot_lo[slot] = lo;
					slot_hi[slot] = hi;
				end
			end
			KIND_REMOVE: begin
				for (int i = 0; i < SLOTS; i++)
					if (slot < 0 && slot_used[i] && slot_key[i] == id)
						slot = i;
				if (slot < 0) begin
					r.st = STATUS_NOT_FOUND;
				end else begin
					slot_used[slot] = 1'b0;
					stored_keys--;
				end
			end
			KIND_CLEAR: begin
				for (int i = 0; i < SLOTS; i++)
					slot_used[i] = 1'b0;
				stored_keys = 0;
			end
			KIND_MATCH_ANY, KIND_MATCH_ALL: begin
				if ((lo | hi) != '0) begin
					for (int i = 0; i < SLOTS; i++) begin
						if (k == KIND_MATCH_ANY)
							hit = ((slot_lo[i] & lo) | (slot_hi[i] & hi)) != '0;
						else
							hit = ((slot_lo[i] & lo) == lo) && ((slot_hi[i] & hi) == hi);
						if (slot_used[i] && hit) begin
							r.mkey = slot_key[i];
							r.hit = 1'b1;
							r.cnt = COUNT_W'(stored_keys);
							r.lst = 1'b0;
							scan_hits.push_back(r);
						end
					end
				end
				if (scan_hits.size() != 0) begin
					r = scan_hits.pop_back();
					r.lst = 1'b1;
				end else begin
					r = '0;
					r.st = STATUS_OK;
					r.lst = 1'b1;
				end
			end
			default: begin
			end
		endcase
		r.cnt = COUNT_W'(stored_keys);
		scan_hits.push_back(r);
	endfunction

	task automatic issue(input request_row_t row);
		table_reply_t typed_reply;
		if ($urandom_range(99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			do
				@(posedge clk);
			while ($urandom_range(99) < tx_idle_pct);
		end
		in_valid <= 1'b1;
		kind <= row.kind;
		key <= row.id;
		bits_low <= row.lo;
		bits_high <= row.hi;
		do
			@(posedge clk);
		while (in_stall);
		apply_request(row.kind, row.id, row.lo, row.hi);
		if (row.typed) begin
			typed_reply = '0;
			typed_reply.st = row.st;
			typed_reply.cnt = row.cnt;
			typed_reply.lst = 1'b1;
			reply_queue.push_back(typed_reply);
		end else begin
			foreach (scan_hits[i])
				reply_queue.push_back(scan_hits[i]);
		end
	endtask

	function automatic void add_row(input logic [KIND_W-1:0] k, input logic [KEY_W-1:0] id,
			input logic [WORD_BITS-1:0] lo, input logic [WORD_BITS-1:0] hi, input logic typed,
			input logic [STATUS_W-1:0] st, input logic [COUNT_W-1:0] cnt);
		request_row_t row;
		row.kind = k;
		row.id = id;
		row.lo = lo;
		row.hi = hi;
		row.typed = typed;
		row.st = st;
		row.cnt = cnt;
		directed_rows.push_back(row);
	endfunction

	function automatic logic [WORD_BITS-1:0] rand_word();
		case ($urandom_range(5))
			0: return '0;
			1: return '1;
			2: return 64'd1 << $urandom_range(63);
			3: return (64'd1 << $urandom_range(63)) | (64'd1 << $urandom_range(63))
					| (64'd1 << $urandom_range(63));
			default: return {$urandom, $urandom};
		endcase
	endfunction

	task automatic random_request(input logic insert_only);
		request_row_t row;
		int pick;
		int sel;
		pick = $urandom_range(99);
		row = '0;
		if (insert_only || pick < 40)
			row.kind = KIND_INSERT;
		else if (pick < 52)
			row.kind = KIND_REMOVE;
		else if (pick < 72)
			row.kind = KIND_MATCH_ANY;
		else if (pick < 92)
			row.kind = KIND_MATCH_ALL;
		else if (pick < 94)
			row.kind = KIND_CLEAR;
		else
			row.kind = KIND_SPARE_FIRST + KIND_W'($urandom_range(2));
		if (insert_only || $urandom_range(99) >= 75)
			row.id = $urandom;
		else
			row.id = key_pool[$urandom_range(POOL - 1)];
		row.lo = rand_word();
		row.hi = rand_word();
		if ((row.kind == KIND_MATCH_ANY || row.kind == KIND_MATCH_ALL) && $urandom_range(1)) begin
			sel = -1;
			pick = $urandom_range(SLOTS - 1);
			for (int i = 0; i < SLOTS; i++)
				if (sel < 0 && slot_used[(pick + i) % SLOTS])
					sel = (pick + i) % SLOTS;
			if (sel >= 0) begin
				row.lo = slot_lo[sel];
				row.hi = slot_hi[sel];
				if ($urandom_range(1)) begin
					row.lo &= {$urandom, $urandom};
					row.hi &= {$urandom, $urandom};
				end
			end
		end
		issue(row);
	endtask

	always @(posedge clk) begin
		if (hold_left > 0) begin
			out_stall <= 1'b1;
			hold_left <= hold_left - 1;
		end else if (hold_req && !hold_done) begin
			out_stall <= 1'b1;
			hold_left <= 400;
			hold_done <= 1'b1;
		end else begin
			out_stall <= ($urandom_range(99) < rx_idle_pct);
		end
	end

	always @(posedge clk) begin : check_replies
		table_reply_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (reply_queue.size() == 0) begin
				$error("unexpected result: match_key %h matched %b status %0d stored_count %0d",
					match_key, matched, status, stored_count);
				err_count++;
			end else begin
				want = reply_queue.pop_front();
				if (match_key !== want.mkey) begin
					$error("match_key: expected %h, actual %h", want.mkey, match_key);
					err_count++;
				end
				if (matched !== want.hit) begin
					$error("matched: expected %b, actual %b", want.hit, matched);
					err_count++;
				end
				if (status !== want.st) begin
					$error("status: expected %0d, actual %0d", want.st, status);
					err_count++;
				end
				if (stored_count !== want.cnt) begin
					$error("stored_count: expected %0d, actual %0d", want.cnt, stored_count);
					err_count++;
				end
				if (last !== want.lst) begin
					$error("last: expected %b, actual %b", want.lst, last);
					err_count++;
				end
			end
		end
	end

	initial begin
		#30000000;
		$display("bitmap_tag_index_table_unit verification failed");
		$finish;
	end

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			slot_used[i] = 1'b0;
			slot_key[i] = '0;
			slot_lo[i] = '0;
			slot_hi[i] = '0;
		end
		key_pool[0] = '0;
		key_pool[1] = '1;
		for (int i = 2; i < POOL; i++)
			key_pool[i] = $urandom;

		add_row(KIND_MATCH_ANY, 32'h0, '1, '1, 1'b1, STATUS_OK, 7'd0);
		add_row(KIND_REMOVE, 32'h5, '0, '0, 1'b1, STATUS_NOT_FOUND, 7'd0);
		add_row(KIND_INSERT, 32'h0, '1, '1, 1'b1, STATUS_OK, 7'd1);
		add_row(KIND_INSERT, 32'hFFFF_FFFF, '0, '0, 1'b1, STATUS_OK, 7'd2);
		add_row(KIND_INSERT, 32'h1234_5678, 64'h1, '0, 1'b1, STATUS_OK, 7'd3);
		add_row(KIND_INSERT, 32'hA5A5_A5A5, '0, 64'h8000_0000_0000_0000, 1'b1, STATUS_OK, 7'd4);
		add_row(KIND_MATCH_ANY, 32'h0, 64'h1, '0, 1'b0, STATUS_OK, 7'd0);
		add_row(KIND_MATCH_ALL, 32'h0, '1, '1, 1'b0, STATUS_OK, 7'd0);
		add_row(KIND_MATCH_ANY, 32'h0, '0, '0, 1'b1, STATUS_OK, 7'd4);
		add_row(KIND_MATCH_ALL, 32'h0, '0, '0, 1'b1, STATUS_OK, 7'd4);
		add_row(KIND_INSERT, 32'h1234_5678, '0, 64'h1, 1'b1, STATUS_OK, 7'd4);
		add_row(KIND_MATCH_ANY, 32'h0, '0, 64'h8000_0000_0000_0000, 1'b0, STATUS_OK, 7'd0);
		add_row(KIND_MATCH_ALL, 32'h0, '0, 64'h1, 1'b0, STATUS_OK, 7'd0);
		add_row(KIND_REMOVE, 32'h0, '0, '0, 1'b1, STATUS_OK, 7'd3);
		add_row(KIND_INSERT, 32'hDEAD_BEEF, 64'h5, '0, 1'b1, STATUS_OK, 7'd4);
		add_row(KIND_MATCH_ANY, 32'h0, '1, '1, 1'b0, STATUS_OK, 7'd0);
		add_row(KIND_SPARE_FIRST, 32'hFFFF_FFFF, '1, '1, 1'b1, STATUS_OK, 7'd4);
		add_row(KIND_SPARE_FIRST + 3'd1, 32'h0, '0, '1, 1'b1, STATUS_OK, 7'd4);
		add_row(KIND_SPARE_FIRST + 3'd2, 32'h0, '1, '0, 1'b1, STATUS_OK, 7'd4);
		add_row(KIND_REMOVE, 32'hFFFF_FFFF, '0, '0, 1'b1, STATUS_OK, 7'd3);
		add_row(KIND_REMOVE, 32'hFFFF_FFFF, '0, '0, 1'b1, STATUS_NOT_FOUND, 7'd3);
		add_row(KIND_CLEAR, 32'h0, '0, '0, 1'b1, STATUS_OK, 7'd0);
		add_row(KIND_MATCH_ANY, 32'h0, '1, '1, 1'b1, STATUS_OK, 7'd0);
		add_row(KIND_INSERT, 32'h0, '1, '1, 1'b1, STATUS_OK, 7'd1);

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		tx_idle_pct <= 29;
		rx_idle_pct <= 49;
		@(posedge clk);

		foreach (directed_rows[i])
			issue(directed_rows[i]);

		for (int n = 0; n < 70; n++)
			random_request(1'b1);
		for (int n = 0; n < 80; n++)
			random_request(1'b0);

		tx_idle_pct <= 49;
		rx_idle_pct <= 29;
		for (int n = 0; n < 150; n++)
			random_request(1'b0);

		tx_idle_pct <= 0;
		rx_idle_pct <= 0;
		hold_req <= 1'b1;
		for (int n = 0; n < 150; n++)
			random_request(1'b0);

		in_valid <= 1'b0;
		while (reply_queue.size() != 0)
			@(posedge clk);
		repeat (100) @(posedge clk);
		if (err_count == 0 && reply_queue.size() == 0)
			$display("bitmap_tag_index_table_unit verification clean");
		else
			$display("bitmap_tag_index_table_unit verification failed");
		$finish;
	end

endmodule
